// ----- sv/cc2d_pkg.sv -----
`timescale 1ns / 1ps

package cc2d_pkg;

	// Fixed field widths of the channels.
	localparam int VALUE_W    = 16;
	localparam int KIDX_W     = 3;
	localparam int SUM_W      = 40;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Limits that the count fields impose.
	localparam int ROW_LIMIT       = 4096;
	localparam int COL_FIELD_LIMIT = 1024;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 2'd3;

	// Command codes of an input word.
	localparam logic CMD_KERNEL = 1'b0;
	localparam logic CMD_PIXEL  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	// Control that travels with a column token or a partial sum.
	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

endpackage

// ----- sv/cc2d_ifs.sv -----
`timescale 1ns / 1ps

interface cc2d_item_if;
	logic                               valid;
	logic                               ready;
	logic                               cmd;
	logic [cc2d_pkg::KIDX_W-1:0]        kernel_row;
	logic [cc2d_pkg::KIDX_W-1:0]        kernel_col;
	logic signed [cc2d_pkg::VALUE_W-1:0] value;

	modport source (output valid, cmd, kernel_row, kernel_col, value, input ready);
	modport sink (input valid, cmd, kernel_row, kernel_col, value, output ready);
endinterface

interface cc2d_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [cc2d_pkg::SUM_W-1:0] sum;
	logic [cc2d_pkg::ROW_W-1:0]        out_row;
	logic [cc2d_pkg::COL_W-1:0]        out_col;
	logic                              last_of_frame;

	modport source (output valid, sum, out_row, out_col, last_of_frame, input ready);
	modport sink (input valid, sum, out_row, out_col, last_of_frame, output ready);
endinterface

interface cc2d_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [cc2d_pkg::CFG_IDX_W-1:0]     index;
	logic [cc2d_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/cross_correlation_2d_valid_top.sv -----
`timescale 1ns / 1ps
// A pixel that completes a window starts the column tokens; its word is valid on the output
// once the last column sum has left the chain and the output register is free.
// Coefficient words and pixels without a window do not hold the input off; a pixel with a
// window holds the input off until its word is loaded, which waits on the column tokens,
// the depth of the cell chain and a free output register. Reset is asynchronous, active low.

// Valid-region 2-D cross-correlation. A chain of MAX_KERNEL cells holds one image row
// each (row r lives in cell r mod MAX_KERNEL) and a copy of the kernel. For every output
// position the sequencer sends one token per kernel column down the chain; each cell reads
// its pixel and the coefficient of the kernel row its bank stands for, and adds the
// product to the partial sum from its left neighbor. The accumulator at the end of the
// chain adds up the column sums. The line store needs no clearing: a window only reads
// rows that the current frame has already written.
module cross_correlation_2d_valid_top #(
	parameter int MAX_KERNEL = 8,
	parameter int MAX_COLS   = 1024,
	parameter int PIXEL_BITS = 16
) (
	input logic           clk,
	input logic           arst_n,
	cc2d_item_if.sink     item,
	cc2d_result_if.source result,
	cc2d_cfg_if.sink      cfg
);

	localparam int VW      = (PIXEL_BITS < cc2d_pkg::VALUE_W) ? PIXEL_BITS : cc2d_pkg::VALUE_W;
	localparam int AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int KW      = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int KAW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1;
	localparam int KCW     = $clog2(MAX_KERNEL + 1);
	localparam int TW      = KW + 1;
	localparam int COL_LIM = (MAX_COLS < cc2d_pkg::COL_FIELD_LIMIT) ? MAX_COLS
		: cc2d_pkg::COL_FIELD_LIMIT;

	// Configuration registers and their effective, clamped values.
	logic [12:0] rows_q;
	logic [10:0] cols_q;
	logic [3:0]  krows_q;
	logic [3:0]  kcols_q;
	logic [12:0] rows_eff;
	logic [10:0] cols_eff;
	logic [KCW-1:0] kr_clamp;
	logic [KCW-1:0] kc_clamp;
	logic [KCW-1:0] kr_eff;
	logic [KCW-1:0] kc_eff;

	// Frame position and sequencer.
	cc2d_pkg::state_t state_q;
	cc2d_pkg::state_t state_d;
	logic [cc2d_pkg::ROW_W-1:0] row_q;
	logic [cc2d_pkg::COL_W-1:0] col_q;
	logic [KW-1:0]   bank_q;
	logic            issuing_q;
	logic [KCW-1:0]  issue_col_q;
	logic [cc2d_pkg::ROW_W-1:0] orow_q;
	logic [cc2d_pkg::COL_W-1:0] ocol_q;
	logic            last_q;
	logic [KW-1:0]   top_q;
	logic signed [cc2d_pkg::SUM_W-1:0] acc_q;

	// Output register.
	logic            out_valid_q;
	logic signed [cc2d_pkg::SUM_W-1:0] out_sum_q;
	logic [cc2d_pkg::ROW_W-1:0] out_row_q;
	logic [cc2d_pkg::COL_W-1:0] out_col_q;
	logic            out_last_q;

	logic cfg_wr;
	logic item_acc;
	logic pix_acc;
	logic coef_acc;
	logic window;
	logic at_last;
	logic col_end;
	logic row_end;
	logic load;
	logic [TW-1:0] top_sum;
	logic [KW-1:0] top_next;
	logic [cc2d_pkg::ROW_W-1:0] orow_next;
	logic [cc2d_pkg::COL_W-1:0] ocol_next;
	logic kwr_ok;
	logic [KAW-1:0] kwr_addr;

	// Chain wiring.
	cc2d_pkg::ctl_t tok_ctl [MAX_KERNEL+1];
	logic [AW-1:0]  tok_addr [MAX_KERNEL+1];
	logic [KW-1:0]  tok_kcol [MAX_KERNEL+1];
	cc2d_pkg::ctl_t acc_ctl [MAX_KERNEL];
	logic signed [cc2d_pkg::SUM_W-1:0] acc_c [MAX_KERNEL+1];

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign item_acc  = item.valid && item.ready;
	assign pix_acc   = item_acc && (item.cmd == cc2d_pkg::CMD_PIXEL);
	assign coef_acc  = item_acc && (item.cmd == cc2d_pkg::CMD_KERNEL);

	// Register values out of range are clamped before use.
	always_comb begin
		if (rows_q == 13'd0) begin
			rows_eff = 13'd1;
		end else if (rows_q > 13'(cc2d_pkg::ROW_LIMIT)) begin
			rows_eff = 13'(cc2d_pkg::ROW_LIMIT);
		end else begin
			rows_eff = rows_q;
		end
		if (cols_q == 11'd0) begin
			cols_eff = 11'd1;
		end else if (cols_q > 11'(COL_LIM)) begin
			cols_eff = 11'(COL_LIM);
		end else begin
			cols_eff = cols_q;
		end
		if (krows_q == 4'd0) begin
			kr_clamp = KCW'(1);
		end else if (krows_q > MAX_KERNEL) begin
			kr_clamp = KCW'(MAX_KERNEL);
		end else begin
			kr_clamp = KCW'(krows_q);
		end
		if (kcols_q == 4'd0) begin
			kc_clamp = KCW'(1);
		end else if (kcols_q > MAX_KERNEL) begin
			kc_clamp = KCW'(MAX_KERNEL);
		end else begin
			kc_clamp = KCW'(kcols_q);
		end
		kr_eff = (rows_eff < 13'(kr_clamp)) ? KCW'(rows_eff) : kr_clamp;
		kc_eff = (cols_eff < 11'(kc_clamp)) ? KCW'(cols_eff) : kc_clamp;
	end

	// Position bookkeeping for the pixel on the input.
	always_comb begin
		window    = (13'(row_q) + 13'd1 >= 13'(kr_eff)) && (11'(col_q) + 11'd1 >= 11'(kc_eff));
		at_last   = (13'(row_q) + 13'd1 == rows_eff) && (11'(col_q) + 11'd1 == cols_eff);
		col_end   = 11'(col_q) + 11'd1 >= cols_eff;
		row_end   = 13'(row_q) + 13'd1 >= rows_eff;
		orow_next = cc2d_pkg::ROW_W'(13'(row_q) + 13'd1 - 13'(kr_eff));
		ocol_next = cc2d_pkg::COL_W'(11'(col_q) + 11'd1 - 11'(kc_eff));
		// The window's top row sits in bank (bank - kernel_rows + 1) mod MAX_KERNEL.
		top_sum   = TW'(bank_q) + TW'(MAX_KERNEL) + TW'(1) - TW'(kr_eff);
		top_next  = (top_sum >= TW'(MAX_KERNEL)) ? KW'(top_sum - TW'(MAX_KERNEL))
			: KW'(top_sum);
		kwr_ok    = (item.kernel_row < MAX_KERNEL) && (item.kernel_col < MAX_KERNEL);
		kwr_addr  = KAW'(item.kernel_row * MAX_KERNEL + item.kernel_col);
		load      = (state_q == cc2d_pkg::ST_HOLD) && (!out_valid_q || result.ready);
	end

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		unique case (state_q)
			cc2d_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (pix_acc && window) begin
					state_d = cc2d_pkg::ST_RUN;
				end
			end
			cc2d_pkg::ST_RUN: begin
				if (acc_ctl[MAX_KERNEL-1].valid && acc_ctl[MAX_KERNEL-1].last) begin
					state_d = cc2d_pkg::ST_HOLD;
				end
			end
			cc2d_pkg::ST_HOLD: begin
				if (!out_valid_q || result.ready) begin
					state_d = cc2d_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cc2d_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cc2d_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: configuration, frame counters, token issue, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= 13'd1024;
			cols_q      <= 11'd1024;
			krows_q     <= 4'd3;
			kcols_q     <= 4'd3;
			row_q       <= '0;
			col_q       <= '0;
			bank_q      <= '0;
			issuing_q   <= 1'b0;
			issue_col_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg.index)
					cc2d_pkg::REG_IMAGE_ROWS:  rows_q  <= cfg.data;
					cc2d_pkg::REG_IMAGE_COLS:  cols_q  <= cfg.data[10:0];
					cc2d_pkg::REG_KERNEL_ROWS: krows_q <= cfg.data[3:0];
					cc2d_pkg::REG_KERNEL_COLS: kcols_q <= cfg.data[3:0];
					default: begin
					end
				endcase
				// Any register write restarts the frame.
				row_q  <= '0;
				col_q  <= '0;
				bank_q <= '0;
			end else if (pix_acc) begin
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q  <= '0;
						bank_q <= '0;
					end else begin
						row_q  <= row_q + 1'b1;
						bank_q <= (bank_q == KW'(MAX_KERNEL - 1)) ? '0 : bank_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (pix_acc && window) begin
				issuing_q   <= 1'b1;
				issue_col_q <= '0;
			end else if (issuing_q) begin
				issue_col_q <= issue_col_q + 1'b1;
				if (issue_col_q + 1'b1 == kc_eff) begin
					issuing_q <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pix_acc && window) begin
			orow_q <= orow_next;
			ocol_q <= ocol_next;
			last_q <= at_last;
			top_q  <= top_next;
			acc_q  <= '0;
		end else if (acc_ctl[MAX_KERNEL-1].valid) begin
			acc_q <= acc_q + acc_c[MAX_KERNEL];
		end
		if (load) begin
			out_sum_q  <= acc_q;
			out_row_q  <= orow_q;
			out_col_q  <= ocol_q;
			out_last_q <= last_q;
		end
	end

	// Column tokens enter the chain at cell 0, one per kernel column.
	always_comb begin
		tok_ctl[0].valid = issuing_q;
		tok_ctl[0].last  = issue_col_q + 1'b1 == kc_eff;
		tok_addr[0]      = AW'(11'(ocol_q) + 11'(issue_col_q));
		tok_kcol[0]      = KW'(issue_col_q);
		acc_c[0]         = '0;
	end

	for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_cell
		cc2d_cell #(
			.IDX        (b),
			.MAX_KERNEL (MAX_KERNEL),
			.MAX_COLS   (MAX_COLS),
			.VW         (VW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_ctl_i  (tok_ctl[b]),
			.tok_addr_i (tok_addr[b]),
			.tok_kcol_i (tok_kcol[b]),
			.top_bank_i (top_q),
			.krows_i    (kr_eff),
			.lwr_en_i   (pix_acc && (bank_q == KW'(b))),
			.lwr_addr_i (AW'(col_q)),
			.wdata_i    (item.value[VW-1:0]),
			.kwr_en_i   (coef_acc && kwr_ok),
			.kwr_addr_i (kwr_addr),
			.acc_i      (acc_c[b]),
			.tok_ctl_o  (tok_ctl[b+1]),
			.tok_addr_o (tok_addr[b+1]),
			.tok_kcol_o (tok_kcol[b+1]),
			.acc_ctl_o  (acc_ctl[b]),
			.acc_o      (acc_c[b+1])
		);
	end

	assign result.valid         = out_valid_q;
	assign result.sum           = out_sum_q;
	assign result.out_row       = out_row_q;
	assign result.out_col       = out_col_q;
	assign result.last_of_frame = out_last_q;

`ifndef SYNTHESIS
	// Column sums only leave the chain while a window is being worked on.
	a_chain_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		acc_ctl[MAX_KERNEL-1].valid |-> state_q == cc2d_pkg::ST_RUN)
		else $error("column sum outside of a window computation");

	// Tokens are issued only in RUN and never past the kernel width.
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issuing_q |-> (state_q == cc2d_pkg::ST_RUN) && (issue_col_q < kc_eff))
		else $error("column token issued out of range");

	// A pixel that completes a window starts token issue in the next cycle.
	a_window_start: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && window |=> issuing_q && (state_q == cc2d_pkg::ST_RUN))
		else $error("window pixel did not start the chain");

	// Leaving HOLD always leaves a word in the output register.
	a_hold_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q && (state_q == cc2d_pkg::ST_IDLE))
		else $error("finished sum lost on the way to the output");
`endif

endmodule

// ----- sv/cc2d_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port memory with a registered read.
module cc2d_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/cc2d_cell.sv -----
`timescale 1ns / 1ps

// One cell of the chain: it owns one line bank and a copy of the kernel,
// multiplies the pixel of its bank by the matching coefficient and adds the
// product to the partial sum handed over by its left neighbor.
module cc2d_cell #(
	parameter int IDX        = 0,
	parameter int MAX_KERNEL = 8,
	parameter int MAX_COLS   = 1024,
	parameter int VW         = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cc2d_pkg::ctl_t              tok_ctl_i,
	input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] tok_addr_i,
	input  logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] tok_kcol_i,
	input  logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] top_bank_i,
	input  logic [$clog2(MAX_KERNEL + 1)-1:0] krows_i,
	input  logic                        lwr_en_i,
	input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] lwr_addr_i,
	input  logic [VW-1:0]               wdata_i,
	input  logic                        kwr_en_i,
	input  logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1)-1:0] kwr_addr_i,
	input  logic signed [cc2d_pkg::SUM_W-1:0] acc_i,
	output cc2d_pkg::ctl_t              tok_ctl_o,
	output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] tok_addr_o,
	output logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] tok_kcol_o,
	output cc2d_pkg::ctl_t              acc_ctl_o,
	output logic signed [cc2d_pkg::SUM_W-1:0] acc_o
);

	localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int KW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int KAW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1;
	localparam int TW  = KW + 1;

	logic [TW-1:0]  krow;
	logic           active;
	logic [KAW-1:0] kaddr;
	logic [VW-1:0]  pix;
	logic [VW-1:0]  coef;

	cc2d_pkg::ctl_t ctl_s1;
	logic [AW-1:0]  addr_s1;
	logic [KW-1:0]  kcol_s1;
	logic           act_s1;
	cc2d_pkg::ctl_t ctl_s2;
	logic signed [2*VW-1:0] prod_s2;
	cc2d_pkg::ctl_t ctl_s3;
	logic signed [cc2d_pkg::SUM_W-1:0] acc_s3;

	// Kernel row served by this bank for the current window.
	always_comb begin
		if (TW'(IDX) >= TW'(top_bank_i)) begin
			krow = TW'(IDX) - TW'(top_bank_i);
		end else begin
			krow = TW'(IDX) + TW'(MAX_KERNEL) - TW'(top_bank_i);
		end
		active = tok_ctl_i.valid && (krow < krows_i);
		kaddr  = KAW'(krow * MAX_KERNEL + tok_kcol_i);
	end

	cc2d_ram #(.DEPTH(MAX_COLS), .WIDTH(VW)) u_line (
		.clk   (clk),
		.we    (lwr_en_i),
		.waddr (lwr_addr_i),
		.wdata (wdata_i),
		.raddr (tok_addr_i),
		.rdata (pix)
	);

	cc2d_ram #(.DEPTH(MAX_KERNEL * MAX_KERNEL), .WIDTH(VW)) u_kernel (
		.clk   (clk),
		.we    (kwr_en_i),
		.waddr (kwr_addr_i),
		.wdata (wdata_i),
		.raddr (kaddr),
		.rdata (coef)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			act_s1 <= 1'b0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= tok_ctl_i;
			act_s1 <= active;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= tok_addr_i;
		kcol_s1 <= tok_kcol_i;
		if (act_s1) begin
			prod_s2 <= $signed(pix) * $signed(coef);
		end else begin
			prod_s2 <= '0;
		end
		acc_s3 <= acc_i + cc2d_pkg::SUM_W'(prod_s2);
	end

	assign tok_ctl_o  = ctl_s1;
	assign tok_addr_o = addr_s1;
	assign tok_kcol_o = kcol_s1;
	assign acc_ctl_o  = ctl_s3;
	assign acc_o      = acc_s3;

endmodule
